// ----- design/rsdm_pkg.sv -----
`default_nettype none

package rsdm_pkg;

    localparam int CFG_W     = 20;
    localparam int TESTS_W   = 8;
    localparam int SUM_W     = 28;
    localparam int DELAY_W   = 20;
    localparam int UPC_W     = 4;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int LANES     = 2;

    localparam logic [1:0] REG_SETTLE  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_TESTS   = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_TEST    = 2'd1;
    localparam logic [1:0] KIND_AVERAGE = 2'd2;

    typedef enum logic [2:0] {
        PH_SETTLE_ON  = 3'd0,
        PH_MEAS_ON    = 3'd1,
        PH_SETTLE_OFF = 3'd2,
        PH_MEAS_OFF   = 3'd3,
        PH_IDLE       = 3'd4,
        PH_AVERAGE    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INC,
        OP_SETTLE,
        OP_MEAS,
        OP_DIV_START,
        OP_AVG_DONE,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_ACTIVE,
        C_MEAS,
        C_NOT_AVG,
        C_DIV_BUSY,
        C_OUT_BUSY
    } ucond_t;

    typedef struct packed {
        uop_t             op;
        ucond_t           cond;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    localparam logic [UPC_W-1:0] U_FETCH    = 4'd0;
    localparam logic [UPC_W-1:0] U_DISPATCH = 4'd1;
    localparam logic [UPC_W-1:0] U_TICK     = 4'd2;
    localparam logic [UPC_W-1:0] U_SETTLE   = 4'd3;
    localparam logic [UPC_W-1:0] U_MEAS     = 4'd4;
    localparam logic [UPC_W-1:0] U_AVG_CHK  = 4'd5;
    localparam logic [UPC_W-1:0] U_DIV_GO   = 4'd6;
    localparam logic [UPC_W-1:0] U_DIV_WAIT = 4'd7;
    localparam logic [UPC_W-1:0] U_AVG_OUT  = 4'd8;
    localparam logic [UPC_W-1:0] U_EMIT     = 4'd9;
    localparam logic [UPC_W-1:0] U_RETURN   = 4'd10;

    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
        ctrl_word_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: U_FETCH};
        unique case (upc)
            U_FETCH:    w = '{op: OP_ACCEPT,    cond: C_NO_INPUT,   target: U_FETCH};
            U_DISPATCH: w = '{op: OP_NONE,      cond: C_NOT_ACTIVE, target: U_AVG_CHK};
            U_TICK:     w = '{op: OP_INC,       cond: C_MEAS,       target: U_MEAS};
            U_SETTLE:   w = '{op: OP_SETTLE,    cond: C_ALWAYS,     target: U_EMIT};
            U_MEAS:     w = '{op: OP_MEAS,      cond: C_ALWAYS,     target: U_EMIT};
            U_AVG_CHK:  w = '{op: OP_NONE,      cond: C_NOT_AVG,    target: U_EMIT};
            U_DIV_GO:   w = '{op: OP_DIV_START, cond: C_NEVER,      target: U_FETCH};
            U_DIV_WAIT: w = '{op: OP_NONE,      cond: C_DIV_BUSY,   target: U_DIV_WAIT};
            U_AVG_OUT:  w = '{op: OP_AVG_DONE,  cond: C_NEVER,      target: U_FETCH};
            U_EMIT:     w = '{op: OP_EMIT,      cond: C_OUT_BUSY,   target: U_EMIT};
            U_RETURN:   w = '{op: OP_NONE,      cond: C_ALWAYS,     target: U_FETCH};
            default:    w = '{op: OP_NONE,      cond: C_ALWAYS,     target: U_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/relay_switch_delay_meter_core.sv -----
`default_nettype none

// Relay switching delay meter. Each input transfer is one microsecond tick carrying the
// contact sense level in s_tdata[0]; each tick yields exactly one result transfer with the
// relay drive level and, when a test or the run completes, a report (m_tuser = 1 per-test
// delays, 2 final averages). The next tick is accepted only once the previous tick's
// result is registered; for the tick that produces the averages this waits on the
// 28-step shift-subtract divider that forms both means in parallel. A new tick is
// accepted while the previous result still waits on m_tready. Configuration is
// written over the APB port: settle_us at 0x0, timeout_us at 0x4, the test count at
// 0x8. After the last average report the block stays idle with the relay released until
// reset.
module relay_switch_delay_meter_core #(
    parameter int TIMER_BITS = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] sense_level
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] relay_drive, [8:1] test_number, [28:9] on_delay_us, [48:29] off_delay_us,
    // [49] on_timed_out, [50] off_timed_out, [70:51] avg_on_us, [90:71] avg_off_us
    output logic [95:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] report_kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = (TIMER_BITS > rsdm_pkg::CFG_W) ? TIMER_BITS : rsdm_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [rsdm_pkg::CFG_W-1:0]   settle_reg;
    logic [rsdm_pkg::CFG_W-1:0]   timeout_reg;
    logic [rsdm_pkg::TESTS_W-1:0] total_reg;

    rsdm_pkg::phase_t             phase_reg;
    logic [TIMER_BITS-1:0]        tick_reg;
    logic [rsdm_pkg::TESTS_W-1:0] done_reg;
    logic                         prior_reg;
    logic                         drive_reg;
    logic [rsdm_pkg::DELAY_W-1:0] held_delay_reg;
    logic                         held_to_reg;
    logic [rsdm_pkg::SUM_W-1:0]   sum_on_reg;
    logic [rsdm_pkg::SUM_W-1:0]   sum_off_reg;
    logic                         sense_reg;

    logic [1:0]                   rep_kind_reg;
    logic [rsdm_pkg::TESTS_W-1:0] rep_num_reg;
    logic [rsdm_pkg::DELAY_W-1:0] rep_don_reg;
    logic [rsdm_pkg::DELAY_W-1:0] rep_doff_reg;
    logic                         rep_ton_reg;
    logic                         rep_toff_reg;
    logic [rsdm_pkg::DELAY_W-1:0] rep_aon_reg;
    logic [rsdm_pkg::DELAY_W-1:0] rep_aoff_reg;

    logic                         m_valid_reg;
    logic [95:0]                  m_data_reg;
    logic [1:0]                   m_user_reg;

    logic [rsdm_pkg::UPC_W-1:0]   upc_reg;
    logic [rsdm_pkg::UPC_W-1:0]   upc_next;
    rsdm_pkg::ctrl_word_t         cw;
    logic                         cond_true;

    logic                         div_busy;
    logic [rsdm_pkg::LANES-1:0][rsdm_pkg::SUM_W-1:0] div_quo;

    logic                         cfg_write;
    logic [CW-1:0]                tick_ext;
    logic [CW-1:0]                settle_lim;
    logic [CW-1:0]                timeout_lim;
    logic                         settle_hit;
    logic                         sense_edge;
    logic                         meas_hit;
    logic [rsdm_pkg::DELAY_W-1:0] delay_val;
    logic [rsdm_pkg::TESTS_W-1:0] done_inc;
    logic                         out_busy;

    function automatic logic [CW-1:0] clamp_limit(input logic [rsdm_pkg::CFG_W-1:0] v);
        logic [CW-1:0] l;
        l = CW'(v);
        if (l > CW'(TMAX)) begin
            l = CW'(TMAX);
        end
        if (l == '0) begin
            l = CW'(1);
        end
        return l;
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg  <= rsdm_pkg::CFG_W'(500000);
            timeout_reg <= rsdm_pkg::CFG_W'(500000);
            total_reg   <= rsdm_pkg::TESTS_W'(10);
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                rsdm_pkg::REG_SETTLE:  settle_reg  <= pwdata[rsdm_pkg::CFG_W-1:0];
                rsdm_pkg::REG_TIMEOUT: timeout_reg <= pwdata[rsdm_pkg::CFG_W-1:0];
                rsdm_pkg::REG_TESTS:   total_reg   <= pwdata[rsdm_pkg::TESTS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rsdm_pkg::REG_SETTLE:  prdata = 32'(settle_reg);
            rsdm_pkg::REG_TIMEOUT: prdata = 32'(timeout_reg);
            rsdm_pkg::REG_TESTS:   prdata = 32'(total_reg);
            default:               prdata = '0;
        endcase
    end

    // datapath compares
    assign tick_ext    = CW'(tick_reg);
    assign settle_lim  = clamp_limit(settle_reg);
    assign timeout_lim = clamp_limit(timeout_reg);
    assign settle_hit  = (tick_ext >= settle_lim);
    assign sense_edge  = (phase_reg == rsdm_pkg::PH_MEAS_ON) ? (prior_reg && !sense_reg)
                                                             : (!prior_reg && sense_reg);
    assign meas_hit    = sense_edge || (tick_ext >= timeout_lim);
    assign delay_val   = tick_ext[rsdm_pkg::DELAY_W-1:0];
    assign done_inc    = done_reg + 1'b1;
    assign out_busy    = m_valid_reg && !m_tready;

    // sequencer
    assign cw       = rsdm_pkg::ucode_rom(upc_reg);
    assign s_tready = (upc_reg == rsdm_pkg::U_FETCH);

    always_comb begin
        unique case (cw.cond)
            rsdm_pkg::C_NEVER:      cond_true = 1'b0;
            rsdm_pkg::C_ALWAYS:     cond_true = 1'b1;
            rsdm_pkg::C_NO_INPUT:   cond_true = !s_tvalid;
            rsdm_pkg::C_NOT_ACTIVE: cond_true = (phase_reg != rsdm_pkg::PH_SETTLE_ON)
                                             && (phase_reg != rsdm_pkg::PH_MEAS_ON)
                                             && (phase_reg != rsdm_pkg::PH_SETTLE_OFF)
                                             && (phase_reg != rsdm_pkg::PH_MEAS_OFF);
            rsdm_pkg::C_MEAS:       cond_true = (phase_reg == rsdm_pkg::PH_MEAS_ON)
                                             || (phase_reg == rsdm_pkg::PH_MEAS_OFF);
            rsdm_pkg::C_NOT_AVG:    cond_true = (phase_reg != rsdm_pkg::PH_AVERAGE);
            rsdm_pkg::C_DIV_BUSY:   cond_true = div_busy;
            rsdm_pkg::C_OUT_BUSY:   cond_true = out_busy;
            default:                cond_true = 1'b0;
        endcase
    end

    always_comb begin
        upc_next = cond_true ? cw.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= rsdm_pkg::U_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    rsdm_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cw.op == rsdm_pkg::OP_DIV_START),
        .dividend ({sum_off_reg, sum_on_reg}),
        .divisor  (done_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= rsdm_pkg::PH_SETTLE_ON;
            tick_reg       <= '0;
            done_reg       <= '0;
            prior_reg      <= 1'b1;
            drive_reg      <= 1'b1;
            held_delay_reg <= '0;
            held_to_reg    <= 1'b0;
            sum_on_reg     <= '0;
            sum_off_reg    <= '0;
        end else begin
            unique case (cw.op)
                rsdm_pkg::OP_INC: begin
                    if (tick_reg != TMAX) begin
                        tick_reg <= tick_reg + 1'b1;
                    end
                end
                rsdm_pkg::OP_SETTLE: begin
                    if (settle_hit) begin
                        tick_reg <= '0;
                        if (phase_reg == rsdm_pkg::PH_SETTLE_ON) begin
                            drive_reg <= 1'b0;
                            phase_reg <= rsdm_pkg::PH_MEAS_ON;
                        end else begin
                            drive_reg <= 1'b1;
                            phase_reg <= rsdm_pkg::PH_MEAS_OFF;
                        end
                    end
                end
                rsdm_pkg::OP_MEAS: begin
                    if (meas_hit) begin
                        tick_reg <= '0;
                        if (phase_reg == rsdm_pkg::PH_MEAS_ON) begin
                            held_delay_reg <= delay_val;
                            held_to_reg    <= !sense_edge;
                            sum_on_reg     <= sum_on_reg + rsdm_pkg::SUM_W'(delay_val);
                            phase_reg      <= rsdm_pkg::PH_SETTLE_OFF;
                        end else begin
                            sum_off_reg <= sum_off_reg + rsdm_pkg::SUM_W'(delay_val);
                            done_reg    <= done_inc;
                            phase_reg   <= (done_inc >= total_reg) ? rsdm_pkg::PH_AVERAGE
                                                                   : rsdm_pkg::PH_SETTLE_ON;
                        end
                    end
                end
                rsdm_pkg::OP_AVG_DONE: begin
                    phase_reg <= rsdm_pkg::PH_IDLE;
                end
                rsdm_pkg::OP_EMIT: begin
                    if (!out_busy) begin
                        prior_reg <= sense_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // report fields
    always_ff @(posedge aclk) begin
        unique case (cw.op)
            rsdm_pkg::OP_ACCEPT: begin
                sense_reg    <= s_tdata[0];
                rep_kind_reg <= rsdm_pkg::KIND_NONE;
                rep_num_reg  <= '0;
                rep_don_reg  <= '0;
                rep_doff_reg <= '0;
                rep_ton_reg  <= 1'b0;
                rep_toff_reg <= 1'b0;
                rep_aon_reg  <= '0;
                rep_aoff_reg <= '0;
            end
            rsdm_pkg::OP_MEAS: begin
                if (meas_hit && (phase_reg == rsdm_pkg::PH_MEAS_OFF)) begin
                    rep_kind_reg <= rsdm_pkg::KIND_TEST;
                    rep_num_reg  <= done_inc;
                    rep_don_reg  <= held_delay_reg;
                    rep_ton_reg  <= held_to_reg;
                    rep_doff_reg <= delay_val;
                    rep_toff_reg <= !sense_edge;
                end
            end
            rsdm_pkg::OP_AVG_DONE: begin
                rep_kind_reg <= rsdm_pkg::KIND_AVERAGE;
                rep_num_reg  <= done_reg;
                if (done_reg != '0) begin
                    rep_aon_reg  <= div_quo[0][rsdm_pkg::DELAY_W-1:0];
                    rep_aoff_reg <= div_quo[1][rsdm_pkg::DELAY_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((cw.op == rsdm_pkg::OP_EMIT) && !out_busy) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cw.op == rsdm_pkg::OP_EMIT) && !out_busy) begin
            m_data_reg <= {5'd0, rep_aoff_reg, rep_aon_reg, rep_toff_reg, rep_ton_reg,
                           rep_doff_reg, rep_don_reg, rep_num_reg, drive_reg};
            m_user_reg <= rep_kind_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- design/rsdm_divider.sv -----
`default_nettype none

module rsdm_divider (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        start,
    input  wire logic [rsdm_pkg::LANES-1:0][rsdm_pkg::SUM_W-1:0] dividend,
    input  wire logic [rsdm_pkg::TESTS_W-1:0]                divisor,
    output logic                                             busy,
    output logic [rsdm_pkg::LANES-1:0][rsdm_pkg::SUM_W-1:0]  quotient
);

    logic [rsdm_pkg::LANES-1:0][rsdm_pkg::SUM_W-1:0]   quo_reg;
    logic [rsdm_pkg::LANES-1:0][rsdm_pkg::SUM_W-1:0]   quo_next;
    logic [rsdm_pkg::LANES-1:0][rsdm_pkg::TESTS_W-1:0] rem_reg;
    logic [rsdm_pkg::LANES-1:0][rsdm_pkg::TESTS_W-1:0] rem_next;
    logic [rsdm_pkg::TESTS_W-1:0]                      div_reg;
    logic [rsdm_pkg::DIV_CNT_W-1:0]                    count_reg;
    logic                                              busy_reg;

    always_comb begin
        logic [rsdm_pkg::TESTS_W:0] trial;
        logic                       fits;
        trial = '0;
        fits  = 1'b0;
        for (int i = 0; i < rsdm_pkg::LANES; i++) begin
            trial       = {rem_reg[i], quo_reg[i][rsdm_pkg::SUM_W-1]};
            fits        = (trial >= {1'b0, div_reg});
            rem_next[i] = fits ? rsdm_pkg::TESTS_W'(trial - {1'b0, div_reg})
                               : trial[rsdm_pkg::TESTS_W-1:0];
            quo_next[i] = {quo_reg[i][rsdm_pkg::SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= rsdm_pkg::DIV_CNT_W'(rsdm_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == rsdm_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- dv/tb_relay_switch_delay_meter_core.sv -----
`timescale 1ns / 1ps

module tb_relay_switch_delay_meter_core;

    typedef struct {
        logic        drive;
        logic [1:0]  kind;
        logic [7:0]  num;
        logic [19:0] on_d;
        logic [19:0] off_d;
        logic        on_to;
        logic        off_to;
        logic [19:0] avg_on;
        logic [19:0] avg_off;
    } meter_out_t;

    typedef enum {ROW_TICK, ROW_WRITE} row_op_t;

    typedef struct {
        row_op_t     op;
        logic [1:0]  reg_idx;
        logic [19:0] value;
        logic        sense;
        bit          typed;
        meter_out_t  want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = 8'd0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [95:0] m_tdata;
    wire  [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    wire  [31:0] prdata;
    wire         pready;

    // predicted meter state and register copy
    logic [19:0] cfg_settle;
    logic [19:0] cfg_timeout;
    logic [7:0]  cfg_tests;
    rsdm_pkg::phase_t cur_phase;
    logic [19:0] tick_cnt;
    logic [7:0]  done_cnt;
    logic        last_sense;
    logic        drive_now;
    logic [19:0] on_delay_held;
    logic        on_to_held;
    logic [27:0] on_sum;
    logic [27:0] off_sum;

    // contact model for well-formed sense sequences
    logic        contact_lvl = 1'b1;
    logic        seen_drive = 1'b1;
    int unsigned hold_ticks = 0;
    int unsigned resp_delay = 3;

    meter_out_t  awaited_out[$];
    stim_row_t   dir_rows[$];
    meter_out_t  no_out;

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned err_cnt = 0;
    int unsigned ticks_sent = 0;
    int unsigned tests_seen = 0;
    int unsigned timeouts_seen = 0;
    int unsigned averages_seen = 0;

    always #4 aclk = ~aclk;

    relay_switch_delay_meter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic meter_out_t plain(input logic drive);
        meter_out_t r;
        r = '{default: '0};
        r.drive = drive;
        return r;
    endfunction

    function automatic stim_row_t tick_row(input logic s);
        return '{ROW_TICK, rsdm_pkg::REG_SETTLE, 20'd0, s, 1'b0, plain(1'b0)};
    endfunction

    function automatic stim_row_t write_row(input logic [1:0] idx, input logic [19:0] val);
        return '{ROW_WRITE, idx, val, 1'b0, 1'b0, plain(1'b0)};
    endfunction

    function automatic stim_row_t typed_row(input logic s, input logic drive);
        return '{ROW_TICK, rsdm_pkg::REG_SETTLE, 20'd0, s, 1'b1, plain(drive)};
    endfunction

    task automatic advance_meter(input logic sense, output meter_out_t r);
        logic        hit;
        logic [19:0] lim;
        r = '{default: '0};
        case (cur_phase)
            rsdm_pkg::PH_SETTLE_ON, rsdm_pkg::PH_SETTLE_OFF: begin
                if (tick_cnt != 20'hFFFFF) tick_cnt = tick_cnt + 20'd1;
                lim = (cfg_settle == 20'd0) ? 20'd1 : cfg_settle;
                if (tick_cnt >= lim) begin
                    drive_now = (cur_phase == rsdm_pkg::PH_SETTLE_ON) ? 1'b0 : 1'b1;
                    cur_phase = (cur_phase == rsdm_pkg::PH_SETTLE_ON) ? rsdm_pkg::PH_MEAS_ON
                                                                      : rsdm_pkg::PH_MEAS_OFF;
                    tick_cnt  = 20'd0;
                end
            end
            rsdm_pkg::PH_MEAS_ON, rsdm_pkg::PH_MEAS_OFF: begin
                if (tick_cnt != 20'hFFFFF) tick_cnt = tick_cnt + 20'd1;
                hit = (cur_phase == rsdm_pkg::PH_MEAS_ON) ? (last_sense && !sense)
                                                          : (!last_sense && sense);
                lim = (cfg_timeout == 20'd0) ? 20'd1 : cfg_timeout;
                if (hit || tick_cnt >= lim) begin
                    if (cur_phase == rsdm_pkg::PH_MEAS_ON) begin
                        on_delay_held = tick_cnt;
                        on_to_held    = !hit;
                        on_sum        = on_sum + tick_cnt;
                        cur_phase     = rsdm_pkg::PH_SETTLE_OFF;
                    end else begin
                        off_sum  = off_sum + tick_cnt;
                        done_cnt = done_cnt + 8'd1;
                        r.kind   = rsdm_pkg::KIND_TEST;
                        r.num    = done_cnt;
                        r.on_d   = on_delay_held;
                        r.on_to  = on_to_held;
                        r.off_d  = tick_cnt;
                        r.off_to = !hit;
                        cur_phase = (done_cnt >= cfg_tests) ? rsdm_pkg::PH_AVERAGE
                                                            : rsdm_pkg::PH_SETTLE_ON;
                    end
                    tick_cnt = 20'd0;
                end
            end
            rsdm_pkg::PH_AVERAGE: begin
                r.kind = rsdm_pkg::KIND_AVERAGE;
                r.num  = done_cnt;
                if (done_cnt != 8'd0) begin
                    r.avg_on  = 20'(on_sum / done_cnt);
                    r.avg_off = 20'(off_sum / done_cnt);
                end
                cur_phase = rsdm_pkg::PH_IDLE;
            end
            default: ;
        endcase
        last_sense = sense;
        r.drive = drive_now;
    endtask

    task automatic send_tick(input logic sense, input bit typed, input meter_out_t want);
        meter_out_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, sense};
        do @(posedge aclk); while (!s_tready);
        advance_meter(sense, r);
        awaited_out.push_back(typed ? want : r);
        ticks_sent++;
        if (r.drive != seen_drive) begin
            seen_drive = r.drive;
            hold_ticks = 0;
            resp_delay = $urandom_range(1, 7);
        end else begin
            hold_ticks++;
        end
        if (hold_ticks >= resp_delay) contact_lvl = seen_drive;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_out.size() != 0);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {12'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rsdm_pkg::REG_SETTLE:  cfg_settle  = val;
            rsdm_pkg::REG_TIMEOUT: cfg_timeout = val;
            rsdm_pkg::REG_TESTS:   cfg_tests   = val[7:0];
            default: ;
        endcase
    endtask

    function automatic logic random_sense();
        // inject noise and contact bounce now and then
        if ($urandom_range(99) < 12) return logic'($urandom_range(1));
        return contact_lvl;
    endfunction

    task automatic check_result(input meter_out_t w, input meter_out_t g);
        if (g.drive !== w.drive) begin
            $error("relay_drive: expected %0d, got %0d", w.drive, g.drive);
            err_cnt++;
        end
        if (g.kind !== w.kind) begin
            $error("report_kind: expected %0d, got %0d", w.kind, g.kind);
            err_cnt++;
        end
        if (g.num !== w.num) begin
            $error("test_number: expected %0d, got %0d", w.num, g.num);
            err_cnt++;
        end
        if (g.on_d !== w.on_d) begin
            $error("on_delay_us: expected %0d, got %0d", w.on_d, g.on_d);
            err_cnt++;
        end
        if (g.off_d !== w.off_d) begin
            $error("off_delay_us: expected %0d, got %0d", w.off_d, g.off_d);
            err_cnt++;
        end
        if (g.on_to !== w.on_to) begin
            $error("on_timed_out: expected %0d, got %0d", w.on_to, g.on_to);
            err_cnt++;
        end
        if (g.off_to !== w.off_to) begin
            $error("off_timed_out: expected %0d, got %0d", w.off_to, g.off_to);
            err_cnt++;
        end
        if (g.avg_on !== w.avg_on) begin
            $error("avg_on_us: expected %0d, got %0d", w.avg_on, g.avg_on);
            err_cnt++;
        end
        if (g.avg_off !== w.avg_off) begin
            $error("avg_off_us: expected %0d, got %0d", w.avg_off, g.avg_off);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        meter_out_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.drive   = m_tdata[0];
                got.num     = m_tdata[8:1];
                got.on_d    = m_tdata[28:9];
                got.off_d   = m_tdata[48:29];
                got.on_to   = m_tdata[49];
                got.off_to  = m_tdata[50];
                got.avg_on  = m_tdata[70:51];
                got.avg_off = m_tdata[90:71];
                got.kind    = m_tuser;
                if (got.kind == rsdm_pkg::KIND_TEST) begin
                    tests_seen++;
                    if (got.on_to) timeouts_seen++;
                    if (got.off_to) timeouts_seen++;
                end
                if (got.kind == rsdm_pkg::KIND_AVERAGE) averages_seen++;
                if (awaited_out.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_cnt++;
                end else begin
                    check_result(awaited_out.pop_front(), got);
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        stim_row_t row;
        int unsigned n;

        no_out        = plain(1'b0);
        cfg_settle    = 20'd500000;
        cfg_timeout   = 20'd500000;
        cfg_tests     = 8'd10;
        cur_phase     = rsdm_pkg::PH_SETTLE_ON;
        tick_cnt      = 20'd0;
        done_cnt      = 8'd0;
        last_sense    = 1'b1;
        drive_now     = 1'b1;
        on_delay_held = 20'd0;
        on_to_held    = 1'b0;
        on_sum        = 28'd0;
        off_sum       = 28'd0;

        // reset state, limit extremes, timeout on first tick, edge beating timeout
        dir_rows.push_back(typed_row(1'b1, 1'b1));
        dir_rows.push_back(write_row(rsdm_pkg::REG_TESTS, 20'd1));
        dir_rows.push_back(write_row(rsdm_pkg::REG_SETTLE, 20'hFFFFF));
        dir_rows.push_back(typed_row(1'b1, 1'b1));
        dir_rows.push_back(write_row(rsdm_pkg::REG_SETTLE, 20'd0));
        dir_rows.push_back(typed_row(1'b0, 1'b0));
        dir_rows.push_back(write_row(rsdm_pkg::REG_TIMEOUT, 20'd0));
        dir_rows.push_back(typed_row(1'b1, 1'b0));
        dir_rows.push_back(write_row(rsdm_pkg::REG_TESTS, 20'd255));
        dir_rows.push_back(write_row(rsdm_pkg::REG_TIMEOUT, 20'hFFFFF));
        dir_rows.push_back(typed_row(1'b1, 1'b1));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(write_row(rsdm_pkg::REG_SETTLE, 20'd2));
        dir_rows.push_back(write_row(rsdm_pkg::REG_TIMEOUT, 20'd3));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b1));
        for (int i = 0; i < 10; i++) dir_rows.push_back(tick_row(1'b1));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.op == ROW_WRITE)
                write_reg(row.reg_idx, row.value);
            else
                send_tick(row.sense, row.typed, row.want);
        end

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = (p == 0) ? 29 : (p == 1) ? 61 : 0;
            snk_idle_pct = (p == 0) ? 61 : (p == 1) ? 29 : 0;
            write_reg(rsdm_pkg::REG_SETTLE, 20'($urandom_range(0, 4)));
            write_reg(rsdm_pkg::REG_TIMEOUT, 20'($urandom_range(0, 10)));
            repeat (175) send_tick(random_sense(), 1'b0, no_out);
        end

        // drop the test count so the run closes after the current test
        write_reg(rsdm_pkg::REG_TESTS, 20'd0);
        n = 0;
        while (cur_phase != rsdm_pkg::PH_IDLE && n < 2000) begin
            send_tick(random_sense(), 1'b0, no_out);
            n++;
        end
        repeat (4) send_tick(random_sense(), 1'b0, no_out);

        s_tvalid <= 1'b0;
        while (awaited_out.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Ran %0d ticks: %0d test reports, %0d edge timeouts, %0d average reports.",
                 ticks_sent, tests_seen, timeouts_seen, averages_seen);
        $display("Covered settle/timeout limits from zero to full scale and 1/255/0 test counts.");
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
